// ===== sv/smw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the sliding window median unit.
// Used by smw_cell and sliding_window_median_unit; no dependencies.
package smw_pkg;

	// Handshake-free link between neighboring cells
	typedef struct packed {
		logic valid;   // cell holds a window sample
		logic le;      // cell value (possibly compacted) orders at or below the new sample
	} smw_link_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic ins;     // a sample transaction is taken this cycle
		logic rm;      // window is full: the oldest sample leaves
		logic clr;     // window length written: empty the window
	} smw_bcast_t;

endpackage

// ===== sv/sliding_window_median_unit.sv =====
`timescale 1ns / 1ps
// Running median filter over the last window_length samples.
// Uses smw_pkg, smw_cell and smw_ring.
//
//   channel        valid / stall                   payload
//   sample in      sample_valid / sample_stall     sample
//   median out     median_valid / median_stall     median
//   config write   window_length_we                window_length
//
// One sample transaction per clock while the input is not stalled. The edge
// that takes a sample updates the cell row and marks a median pending; the
// median cell is then registered into the output once the output register is
// free. The cell row updates every cell at once; the ring keeps arrival order
// and prefetches the leaving sample into its registered read port.
// Input stalls only while a median is pending and the output register is
// held. No clearing pass after reset; a window_length write empties the window.
module sliding_window_median_unit #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           window_length_we,
	input  logic [6:0]                     window_length,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           median_valid,
	input  logic                           median_stall,
	output logic signed [SAMPLE_WIDTH-1:0] median
);
	import smw_pkg::*;

	localparam int IW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW    = $clog2(WINDOW_MAX + 1);
	localparam int K_RST = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;
	localparam int M_RST = (K_RST - 1) / 2;

	logic [CW-1:0] k_q;
	logic [IW-1:0] mid_q;
	logic [CW-1:0] k_d;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_inc;
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] ptr_inc;
	logic [IW-1:0] ptr_next;
	logic          full;
	logic          gives_result;
	logic          accept;
	logic          s1_q;
	logic          s1_move;
	logic          out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic signed [SAMPLE_WIDTH-1:0] old_v;
	smw_bcast_t    bc;

	smw_link_t                     dn_link [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] dn_v   [WINDOW_MAX];
	smw_link_t                     up_link [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] up_v   [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] cell_v [WINDOW_MAX];

	// Clamp the written length to 1..WINDOW_MAX
	always_comb begin
		if (window_length == 7'd0) begin
			k_d = CW'(1);
		end else if (int'(window_length) > WINDOW_MAX) begin
			k_d = CW'(WINDOW_MAX);
		end else begin
			k_d = CW'(window_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= CW'(K_RST);
			mid_q <= IW'(M_RST);
		end else if (window_length_we) begin
			k_q   <= k_d;
			mid_q <= IW'((k_d - CW'(1)) >> 1);
		end
	end

	// Handshake and window bookkeeping
	always_comb begin
		s1_move      = s1_q && (!out_valid_q || !median_stall);
		sample_stall = s1_q && out_valid_q && median_stall;
		accept       = sample_valid && !sample_stall;
		full         = (fill_q == k_q);
		fill_inc     = fill_q + CW'(1);
		gives_result = full || (fill_inc == k_q);
		ptr_inc      = CW'(ptr_q) + CW'(1);
		if (window_length_we) begin
			ptr_next = '0;
		end else if (accept) begin
			ptr_next = (ptr_inc >= k_q) ? '0 : IW'(ptr_inc);
		end else begin
			ptr_next = ptr_q;
		end
		bc = '{ins: accept, rm: accept && full, clr: window_length_we};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
		end else begin
			ptr_q <= ptr_next;
			if (window_length_we) begin
				fill_q <= '0;
			end else if (accept && !full) begin
				fill_q <= fill_inc;
			end
		end
	end

	// Arrival ring: write the new sample, prefetch the next leaving one
	smw_ring #(
		.W     (SAMPLE_WIDTH),
		.DEPTH (WINDOW_MAX),
		.AW    (IW)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (ptr_q),
		.wdata (sample),
		.raddr (ptr_next),
		.rdata (old_v)
	);

	// Sorted cell row
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		smw_link_t                     hi_link;
		logic signed [SAMPLE_WIDTH-1:0] hi_v;
		smw_link_t                     lo_link;
		logic signed [SAMPLE_WIDTH-1:0] lo_v;

		if (i == WINDOW_MAX - 1) begin : g_top
			assign hi_link = '{valid: 1'b0, le: 1'b0};
			assign hi_v    = '0;
		end else begin : g_mid
			assign hi_link = dn_link[i+1];
			assign hi_v    = dn_v[i+1];
		end

		if (i == 0) begin : g_bot
			assign lo_link = '{valid: 1'b1, le: 1'b1};
			assign lo_v    = '0;
		end else begin : g_low
			assign lo_link = up_link[i-1];
			assign lo_v    = up_v[i-1];
		end

		smw_cell #(
			.W (SAMPLE_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc),
			.x       (sample),
			.old     (old_v),
			.hi_link (hi_link),
			.hi_v    (hi_v),
			.lo_link (lo_link),
			.lo_v    (lo_v),
			.dn_link (dn_link[i]),
			.dn_v    (dn_v[i]),
			.up_link (up_link[i]),
			.up_v    (up_v[i]),
			.value   (cell_v[i])
		);
	end

	// Mark a pending median, then register the middle cell into the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_q <= gives_result;
			end else if (s1_move) begin
				s1_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!median_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= cell_v[mid_q];
		end
	end

	assign median_valid = out_valid_q;
	assign median       = out_q;

endmodule

// ===== sv/smw_ring.sv =====
`timescale 1ns / 1ps
// Arrival-order sample ring: one write port, one registered read port.
// Read data forwards a write to the same slot in the same cycle. No package use.
module smw_ring #(
	parameter int W     = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic         clk,
	input  logic         we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// Write the newest sample into its slot
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ahead, forwarding a same-slot write
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/smw_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted window: holds a sample and a valid bit.
// Removes the leaving sample and inserts the new one using neighbor links; uses smw_pkg.
module smw_cell #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smw_pkg::smw_bcast_t  bc,
	input  logic signed [W-1:0]  x,
	input  logic signed [W-1:0]  old,
	// from the cell above (higher sorted index)
	input  smw_pkg::smw_link_t   hi_link,
	input  logic signed [W-1:0]  hi_v,
	// from the cell below: its compacted value and status
	input  smw_pkg::smw_link_t   lo_link,
	input  logic signed [W-1:0]  lo_v,
	// to the cell below
	output smw_pkg::smw_link_t   dn_link,
	output logic signed [W-1:0]  dn_v,
	// to the cell above
	output smw_pkg::smw_link_t   up_link,
	output logic signed [W-1:0]  up_v,
	output logic signed [W-1:0]  value
);
	import smw_pkg::*;

	logic signed [W-1:0] v_q;
	logic                valid_q;
	logic                le;
	logic                below_rm;
	logic                keep;
	logic signed [W-1:0] cmp_v;
	logic                cmp_le;
	logic signed [W-1:0] v_d;

	// Compare against the new and the leaving sample
	always_comb begin
		le       = valid_q && (v_q <= x);
		below_rm = valid_q && (v_q < old);
		keep     = !bc.rm || below_rm;
		cmp_v    = keep ? v_q : hi_v;
		cmp_le   = keep ? le : hi_link.le;
		if (cmp_le) begin
			v_d = cmp_v;
		end else if (lo_link.le) begin
			v_d = x;
		end else begin
			v_d = lo_v;
		end
	end

	// Hand status to neighbors
	assign dn_link = '{valid: valid_q, le: le};
	assign dn_v    = v_q;
	assign up_link = '{valid: valid_q, le: cmp_le};
	assign up_v    = cmp_v;
	assign value   = v_q;

	// Advance the sample on each transaction
	always_ff @(posedge clk) begin
		if (bc.ins) begin
			v_q <= v_d;
		end
	end

	// Grow the window while filling, drop it on a length write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bc.clr) begin
			valid_q <= 1'b0;
		end else if (bc.ins && !bc.rm) begin
			valid_q <= lo_link.valid;
		end
	end

endmodule
